>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the encoder velocity block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/euve_pkg.sv
// Package for the encoder unwrap and velocity estimator: constants, state and
// command types shared by the controller, the datapath and the top level. No dependencies.
package euve_pkg;

	// Moving average depth and derived widths. The depth must be a power of two,
	// since the ring mean is taken with a shift.
	localparam int AVG_DEPTH = 8;
	localparam int IDX_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int AVG_SHIFT = $clog2(AVG_DEPTH);
	localparam int SUM_W     = 32 + $clog2(AVG_DEPTH);

	// Fixed arithmetic constants.
	localparam logic [31:0] HALF_SPAN = 32'h0000_8000;
	localparam logic [15:0] HALF_LOW  = 16'h8000;
	localparam logic [19:0] US_PER_S  = 20'd1000000;

	// Divider geometry: dividend holds |change| * 1e6, divisor is 16 bits.
	localparam int DIV_W      = 52;
	localparam int DVS_W      = 16;
	localparam int DIV_STEP   = 2;
	localparam int DIV_CYCLES = DIV_W / DIV_STEP;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

	// Register port.
	localparam int PADDR_W = 3;
	localparam logic REG_INVERT = 1'b0;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UNWRAP,
		S_POS,
		S_CHANGE,
		S_ABS,
		S_MUL,
		S_DIV_RAW,
		S_WAIT_RAW,
		S_SAT,
		S_COMMIT,
		S_FINISH
	} euve_state_t;

	typedef struct packed {
		logic load;
		logic unwrap;
		logic pos;
		logic change;
		logic abs_val;
		logic mul;
		logic div_start;
		logic sat;
		logic commit;
		logic out_load;
	} euve_cmd_t;

	typedef struct packed {
		logic div_done;
	} euve_status_t;

endpackage

>>> rtl/euve_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module euve_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/euve_div.sv
// Unsigned restoring divider, two quotient bits per cycle, used for the raw
// velocity. Depends on euve_pkg.
module euve_div import euve_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0]     rq_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DIV_W-1:0]     rq_w;
	logic [DVS_W-1:0]     rem_w;

	// Two restoring steps: shift in a dividend bit, subtract when it fits.
	always_comb begin
		logic [DVS_W:0] sh;
		rq_w  = rq_q;
		rem_w = rem_q;
		sh    = '0;
		for (int i = 0; i < DIV_STEP; i++) begin
			sh   = {rem_w, rq_w[DIV_W-1]};
			rq_w = {rq_w[DIV_W-2:0], 1'b0};
			if (sh >= {1'b0, dvs_q}) begin
				sh       = sh - {1'b0, dvs_q};
				rq_w[0]  = 1'b1;
			end
			rem_w = sh[DVS_W-1:0];
		end
	end

	// Iteration counter and done flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DIV_CNT_W'(DIV_CYCLES);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	// Shared dividend/quotient shift register and partial remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			rq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rq_q  <= rq_w;
			rem_q <= rem_w;
		end
	end

	assign done     = done_q;
	assign quotient = rq_q;

endmodule

>>> rtl/euve_dp.sv
// Datapath: count unwrap, position change, velocity scaling, ring buffer,
// running sum and output registers. Depends on euve_pkg, euve_div, euve_ram.
module euve_dp import euve_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  euve_cmd_t           cmd,
	output euve_status_t        status,
	input  logic                invert,
	input  logic [15:0]         counter_reading,
	input  logic [15:0]         dt_us,
	output logic signed [31:0]  position,
	output logic signed [31:0]  velocity,
	output logic signed [15:0]  velocity_short
);

	logic [15:0]             reading_q;
	logic [DVS_W-1:0]        dt_q;
	logic [31:0]             unwrapped_q;
	logic [31:0]             last_pos_q;
	logic [31:0]             pos_q;
	logic signed [31:0]      change_q;
	logic [31:0]             mag_q;
	logic                    neg_q;
	logic [DIV_W-1:0]        prod_q;
	logic signed [31:0]      old_q;
	logic signed [31:0]      raw_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [IDX_W-1:0]        idx_q;
	logic [AVG_DEPTH-1:0]    valid_q;
	logic signed [31:0]      position_q;
	logic signed [31:0]      velocity_q;
	logic signed [15:0]      vshort_q;

	logic [15:0]             low_w;
	logic [31:0]             pos_w;
	logic signed [SUM_W-1:0] round_w;
	logic signed [SUM_W-1:0] sum_adj_w;
	logic                    div_done;
	logic [DIV_W-1:0]        quot;
	logic [31:0]             ram_rdata;
	logic signed [31:0]      raw_w;
	logic signed [31:0]      avg_w;
	logic signed [15:0]      short_w;

	// Wrapped 16-bit difference against the offset count, and the reported position.
	assign low_w = reading_q - HALF_LOW - unwrapped_q[15:0];
	assign pos_w = unwrapped_q + HALF_SPAN;

	euve_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (dt_q),
		.done     (div_done),
		.quotient (quot)
	);

	assign status.div_done = div_done;

	euve_ram #(
		.WIDTH (32),
		.DEPTH (AVG_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (idx_q),
		.wdata (raw_q),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	// Raw velocity: apply the sign and saturate to signed 32 bits.
	always_comb begin
		if (!neg_q) begin
			raw_w = (quot > DIV_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : signed'(quot[31:0]);
		end else begin
			raw_w = (quot > DIV_W'(32'h8000_0000)) ? 32'sh8000_0000 : -signed'(quot[31:0]);
		end
	end

	// Ring mean truncated toward zero: a negative sum is biased by depth - 1
	// before the arithmetic shift.
	assign round_w   = sum_q[SUM_W-1] ? SUM_W'(AVG_DEPTH - 1) : SUM_W'(0);
	assign sum_adj_w = sum_q + round_w;
	assign avg_w     = 32'(sum_adj_w >>> AVG_SHIFT);

	// The 16-bit saturated copy of the mean.
	always_comb begin
		if (avg_w > 32'sd32767) begin
			short_w = 16'sh7FFF;
		end else if (avg_w < -32'sd32768) begin
			short_w = 16'sh8000;
		end else begin
			short_w = avg_w[15:0];
		end
	end

	// State that reset clears: count, last position, ring index, sum and valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unwrapped_q <= '0;
			last_pos_q  <= '0;
			idx_q       <= '0;
			sum_q       <= '0;
			valid_q     <= '0;
		end else begin
			if (cmd.unwrap) begin
				unwrapped_q <= unwrapped_q + 32'(signed'(low_w));
			end
			if (cmd.change) begin
				last_pos_q <= pos_q;
			end
			if (cmd.commit) begin
				sum_q          <= sum_q - SUM_W'(old_q) + SUM_W'(raw_q);
				valid_q[idx_q] <= 1'b1;
				idx_q          <= (idx_q == IDX_W'(AVG_DEPTH - 1)) ? '0 : idx_q + 1'b1;
			end
		end
	end

	// Working and output payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			reading_q <= counter_reading;
			dt_q      <= (dt_us == '0) ? DVS_W'(1) : dt_us;
		end
		if (cmd.pos) begin
			pos_q <= invert ? (32'd0 - pos_w) : pos_w;
		end
		if (cmd.change) begin
			change_q <= signed'(pos_q - last_pos_q);
		end
		if (cmd.abs_val) begin
			neg_q <= change_q[31];
			mag_q <= change_q[31] ? 32'(-change_q) : 32'(change_q);
		end
		if (cmd.mul) begin
			prod_q <= DIV_W'(mag_q) * DIV_W'(US_PER_S);
			old_q  <= valid_q[idx_q] ? signed'(ram_rdata) : 32'sd0;
		end
		if (cmd.sat) begin
			raw_q <= raw_w;
		end
		if (cmd.out_load) begin
			position_q <= signed'(pos_q);
			velocity_q <= avg_w;
			vshort_q   <= short_w;
		end
	end

	assign position       = position_q;
	assign velocity       = velocity_q;
	assign velocity_short = vshort_q;

endmodule

>>> rtl/euve_ctrl.sv
// Controller: sequences one item through the datapath and owns both handshakes.
// Depends on euve_pkg.
module euve_ctrl import euve_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  euve_status_t status,
	output euve_cmd_t    cmd
);

	euve_state_t state_q;
	euve_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;

	// State register and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_UNWRAP;
				end
			end
			S_UNWRAP: begin
				cmd.unwrap = 1'b1;
				state_d    = S_POS;
			end
			S_POS: begin
				cmd.pos = 1'b1;
				state_d = S_CHANGE;
			end
			S_CHANGE: begin
				cmd.change = 1'b1;
				state_d    = S_ABS;
			end
			S_ABS: begin
				cmd.abs_val = 1'b1;
				state_d     = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV_RAW;
			end
			S_DIV_RAW: begin
				cmd.div_start = 1'b1;
				state_d       = S_WAIT_RAW;
			end
			S_WAIT_RAW: begin
				if (status.div_done) begin
					state_d = S_SAT;
				end
			end
			S_SAT: begin
				cmd.sat = 1'b1;
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/encoder_unwrap_velocity_estimator.sv
// Encoder count unwrap with moving-average velocity. One item at a time: out_valid
// rises on the edge that returns the controller to idle, and the next item can be taken
// in that cycle, so a new item is taken only once the last is through; results leave at once.
// The serial divider for change over dt runs two quotient bits per cycle;
// a result still waiting holds the next item in its last state. Reset clears the count,
// last position, ring index, sum, ring valid bits and inversion at once; no clearing pass.
module encoder_unwrap_velocity_estimator import euve_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        counter_reading,
	input  logic [15:0]        dt_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] position,
	output logic signed [31:0] velocity,
	output logic signed [15:0] velocity_short,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	euve_cmd_t    cmd;
	euve_status_t status;
	logic         invert_q;
	logic         reg_hit;

	// Register port: a single inversion bit, writes complete in the access cycle.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_INVERT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b0;
		end else if (psel && penable && pwrite && reg_hit) begin
			invert_q <= pwdata[0];
		end
	end

	assign prdata = reg_hit ? {31'd0, invert_q} : 32'd0;

	euve_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	euve_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.invert          (invert_q),
		.counter_reading (counter_reading),
		.dt_us           (dt_us),
		.position        (position),
		.velocity        (velocity),
		.velocity_short  (velocity_short)
	);

endmodule

>>> rtl/euve_checker.sv
// Port-level checker for the encoder velocity block and its bind to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module euve_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] position,
	input logic signed [31:0] velocity,
	input logic signed [15:0] velocity_short
);

	// One item at a time: the input closes right after an item is taken.
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)

	// A stalled result holds its fields.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(position) && $stable(velocity) && $stable(velocity_short))

	// The short velocity is the averaged velocity saturated to 16 bits.
	`ASSERT_SAME(a_short_sat, clk, arst_n, out_valid,
		(velocity > 32'sd32767) ? (velocity_short == 16'sh7FFF) :
		((velocity < -32'sd32768) ? (velocity_short == 16'sh8000) :
		(velocity_short == velocity[15:0])))

endmodule

bind encoder_unwrap_velocity_estimator euve_checker u_checker (.*);

>>> tb/tb_encoder_unwrap_velocity_estimator.sv
// Self-checking testbench for encoder_unwrap_velocity_estimator: a scoreboard
// class predicts position and averaged velocity for every accepted item.
// Depends on euve_pkg and the block's RTL only.
module tb_encoder_unwrap_velocity_estimator import euve_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint MICROS_PER_SEC = 1000000;
	localparam longint SAT32_MAX      = 64'sd2147483647;
	localparam longint SAT32_MIN      = -64'sd2147483648;
	localparam longint SAT16_MAX      = 32767;
	localparam longint SAT16_MIN      = -32768;
	localparam logic [15:0] HALF_COUNT = 16'h8000;
	localparam logic [PADDR_W-1:0] INVERT_ADDR = PADDR_W'(4 * int'(REG_INVERT));
	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE_CYCLES = 80;

	// One expected output item.
	typedef struct {
		int      position;
		int      velocity;
		shortint velocity_short;
	} motion_est_t;

	// Tracks the block's count, ring and inversion setting and queues the
	// motion estimate that each accepted item should produce.
	class motion_scoreboard;
		bit [31:0]   count_acc;
		bit [31:0]   prev_pos;
		int          vel_ring[AVG_DEPTH];
		int unsigned slot;
		bit          invert;
		motion_est_t pending_motion[$];
		int          errors;

		function new();
			count_acc = '0;
			prev_pos  = '0;
			slot      = 0;
			invert    = 1'b0;
			errors    = 0;
			foreach (vel_ring[i])
				vel_ring[i] = 0;
		endfunction

		function void set_invert(bit v);
			invert = v;
		endfunction

		task report(string msg);
			$display("%0t ns: mismatch: %s", $realtime, msg);
			errors++;
		endtask

		// Unwrap the reading, derive the raw velocity and average the ring.
		function void note_sample(bit [15:0] reading, bit [15:0] dt);
			bit [15:0]   low;
			bit [31:0]   pos;
			int          step_diff;
			longint      change;
			longint      raw;
			longint      span;
			longint      sum;
			longint      avg;
			longint      short_avg;
			motion_est_t est;

			low = reading - HALF_COUNT - count_acc[15:0];
			count_acc += {{16{low[15]}}, low};
			pos = count_acc + 32'h0000_8000;
			if (invert)
				pos = 32'd0 - pos;

			// Zero elapsed time is taken as one microsecond.
			step_diff = int'(pos - prev_pos);
			change = step_diff;
			span = (dt == 16'd0) ? 1 : longint'(dt);
			raw = (change * MICROS_PER_SEC) / span;
			if (raw > SAT32_MAX)
				raw = SAT32_MAX;
			else if (raw < SAT32_MIN)
				raw = SAT32_MIN;
			prev_pos = pos;

			vel_ring[slot] = int'(raw);
			slot = (slot + 1) % AVG_DEPTH;
			sum = 0;
			foreach (vel_ring[i])
				sum += vel_ring[i];
			avg = sum / AVG_DEPTH;
			short_avg = avg;
			if (short_avg > SAT16_MAX)
				short_avg = SAT16_MAX;
			else if (short_avg < SAT16_MIN)
				short_avg = SAT16_MIN;

			est.position       = int'(pos);
			est.velocity       = int'(avg);
			est.velocity_short = shortint'(short_avg);
			pending_motion.push_back(est);
		endfunction

		task check_result(logic signed [31:0] pos, logic signed [31:0] vel,
				logic signed [15:0] vel_short);
			motion_est_t est;
			if (pending_motion.size() == 0) begin
				report("result item with no input item pending");
			end else begin
				est = pending_motion.pop_front();
				if (pos !== est.position)
					report($sformatf("position got %0d expected %0d", pos, est.position));
				if (vel !== est.velocity)
					report($sformatf("velocity got %0d expected %0d", vel, est.velocity));
				if (vel_short !== est.velocity_short)
					report($sformatf("velocity_short got %0d expected %0d",
						vel_short, est.velocity_short));
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [15:0]        counter_reading;
	logic [15:0]        dt_us;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] position;
	logic signed [31:0] velocity;
	logic signed [15:0] velocity_short;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	motion_scoreboard sb = new();
	bit               steady;
	int               cycles;
	logic [15:0]      enc_reading;

	encoder_unwrap_velocity_estimator u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.counter_reading(counter_reading),
		.dt_us          (dt_us),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.position       (position),
		.velocity       (velocity),
		.velocity_short (velocity_short),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_encoder_unwrap_velocity_estimator: errors");
			$finish;
		end
	end

	// Monitors: predict on accepted input items, check accepted result items.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_sample(counter_reading, dt_us);
		if (arst_n && out_valid && out_ready)
			sb.check_result(position, velocity, velocity_short);
	end

	// Mostly short gaps, now and then a long one; none in steady stretches.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(50, 200);
	endfunction

	// Receiver back-pressure.
	initial begin
		int hold;
		hold = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (steady) begin
				out_ready = 1'b1;
				hold = 0;
			end else if (hold > 0) begin
				out_ready = 1'b0;
				hold--;
			end else begin
				out_ready = 1'b1;
				if ($urandom_range(0, 9) < 3)
					hold = pick_gap();
			end
		end
	end

	// Present one item, hold it until accepted, then idle for a random gap.
	task automatic send_sample(logic [15:0] reading, logic [15:0] dt);
		int gap;
		in_valid        = 1'b1;
		counter_reading = reading;
		dt_us           = dt;
		enc_reading     = reading;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
		in_valid = 1'b0;
		gap = pick_gap();
		repeat (gap) @(negedge clk);
	endtask

	task automatic wait_for_results();
		while (sb.pending_motion.size() != 0)
			@(negedge clk);
	endtask

	// Write the inversion register with random upper bits, then read it back.
	task automatic write_invert(bit v);
		logic [31:0] wdata;
		wdata = $urandom();
		wdata[0] = v;
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = INVERT_ADDR;
		pwdata  = wdata;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		sb.set_invert(v);
		pwrite  = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== {31'd0, v})
			sb.report($sformatf("invert_encoder read back %0h expected %0h", prdata, v));
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Random items: half small realistic steps, the rest arbitrary jumps, moderate
	// steps and short intervals that push the raw velocity into saturation.
	task automatic random_samples(int n);
		int kind;
		logic [15:0] rd;
		logic [15:0] dt;
		repeat (n) begin
			kind = $urandom_range(0, 99);
			if (kind < 50) begin
				rd = enc_reading + 16'($urandom_range(0, 400) - 200);
				dt = 16'($urandom_range(50, 5000));
			end else if (kind < 75) begin
				rd = 16'($urandom());
				dt = 16'($urandom());
			end else if (kind < 90) begin
				rd = enc_reading + 16'($urandom_range(0, 65535));
				dt = 16'($urandom_range(0, 10));
			end else begin
				rd = enc_reading + 16'($urandom_range(0, 2000) - 1000);
				dt = 16'($urandom_range(1, 65535));
			end
			send_sample(rd, dt);
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		counter_reading = '0;
		dt_us           = '0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		steady          = 1'b0;
		cycles          = 0;
		enc_reading     = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed items, inversion off: extremes, half-period step, zero dt,
		// saturated velocities in both directions and counter wrap-around.
		write_invert(1'b0);
		send_sample(16'h0000, 16'd1);
		send_sample(16'h8000, 16'd0);
		send_sample(16'hFFFF, 16'd1);
		send_sample(16'h7FFF, 16'd65535);
		send_sample(16'h0000, 16'd0);
		send_sample(16'hFFFF, 16'd1000);
		send_sample(16'h0001, 16'd1000);
		send_sample(16'h0001, 16'hFFFF);
		send_sample(16'h8001, 16'd1);
		send_sample(16'h8001, 16'h8000);
		send_sample(16'h0002, 16'h7FFF);
		send_sample(16'h5555, 16'h5555);
		send_sample(16'hAAAA, 16'hAAAA);
		wait_for_results();

		// Directed items, inversion on.
		write_invert(1'b1);
		send_sample(16'hAAAB, 16'd100);
		send_sample(16'h2AAB, 16'd0);
		send_sample(16'hAAAB, 16'd1);
		send_sample(16'h0000, 16'd20);
		send_sample(16'hFFF0, 16'd20);
		send_sample(16'h0010, 16'hFFFF);
		send_sample(16'h0010, 16'd7);
		wait_for_results();

		// Random phases with changing inversion; each drains before the write.
		for (int phase = 0; phase < 6; phase++) begin
			write_invert((phase == 5) ? 1'b0 : 1'($urandom_range(0, 1)));
			steady = (phase == 2);
			random_samples(100);
			steady = 1'b0;
			wait_for_results();
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.pending_motion.size() != 0)
			sb.report("expected result items never arrived");
		if (sb.errors == 0)
			$display("tb_encoder_unwrap_velocity_estimator: clean");
		else
			$display("tb_encoder_unwrap_velocity_estimator: errors");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/euve_pkg.sv
rtl/euve_ram.sv
rtl/euve_div.sv
rtl/euve_dp.sv
rtl/euve_ctrl.sv
rtl/encoder_unwrap_velocity_estimator.sv
rtl/euve_checker.sv
tb/tb_encoder_unwrap_velocity_estimator.sv
